>>> hdl/sync_header_frame_decoder_crc16_defines.svh
// Assertion macros shared by the frame decoder checkers.
// No dependencies; included by the checker file.
`ifndef SYNC_HEADER_FRAME_DECODER_CRC16_DEFINES_SVH
`define SYNC_HEADER_FRAME_DECODER_CRC16_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define SHFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define SHFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/shfd_pkg.sv
// Types, codes and the CRC-16/MODBUS byte update for the frame decoder.
// No dependencies.
package shfd_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [8:0]  HDR_BYTES   = 9'd6;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_SYNC  = 2'd1,
      STATUS_TRUNCATED = 2'd2,
      STATUS_CRC_BAD   = 2'd3
   } status_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      status_type frame_status;
      logic [7:0] dest_addr;
      logic [7:0] source_addr;
      logic [7:0] command_code;
      logic [7:0] payload_length;
   } result_type;

   // Reflected CRC, eight bit steps unrolled.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hdl/shfd_core.sv
// Frame parsing state and per-byte decode for the frame decoder.
// Depends on shfd_pkg.
module shfd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             rx_byte,
   input  logic                   buffer_first,
   input  logic                   buffer_last,
   output logic                   result_valid,
   output shfd_pkg::result_type   result
);

   logic [8:0]  pos_ff, pos_in, pos_cur;
   logic [15:0] crc_ff, crc_in, crc_cur, crc_upd;
   logic [7:0]  dest_ff, dest_in, dest_cur;
   logic [7:0]  src_ff, src_in, src_cur;
   logic [7:0]  cmd_ff, cmd_in, cmd_cur;
   logic [7:0]  len_ff, len_in, len_cur;
   logic [7:0]  low_ff, low_in, low_cur;
   logic        verdict_ff, verdict_in, verdict_cur;
   logic [8:0]  pay_end;
   logic        emit_status, emit_payload;
   shfd_pkg::status_type status_code;

   always_comb begin
      pos_cur     = buffer_first ? '0 : pos_ff;
      crc_cur     = buffer_first ? shfd_pkg::CRC_INIT : crc_ff;
      dest_cur    = buffer_first ? '0 : dest_ff;
      src_cur     = buffer_first ? '0 : src_ff;
      cmd_cur     = buffer_first ? '0 : cmd_ff;
      len_cur     = buffer_first ? '0 : len_ff;
      low_cur     = buffer_first ? '0 : low_ff;
      verdict_cur = buffer_first ? 1'b0 : verdict_ff;

      pos_in = pos_cur;
      crc_in = crc_cur;
      dest_in = dest_cur;
      src_in = src_cur;
      cmd_in = cmd_cur;
      len_in = len_cur;
      low_in = low_cur;
      verdict_in = verdict_cur;

      crc_upd = shfd_pkg::crc_byte(crc_cur, rx_byte);
      pay_end = shfd_pkg::HDR_BYTES + {1'b0, len_cur};
      emit_status  = 1'b0;
      emit_payload = 1'b0;
      status_code  = shfd_pkg::STATUS_OK;

      if (!verdict_cur) begin
         pos_in = pos_cur + 9'd1;
         if (pos_cur == 9'd0 || pos_cur == 9'd1) begin
            if (rx_byte != ((pos_cur == 9'd0) ? shfd_pkg::SYNC_FIRST : shfd_pkg::SYNC_SECOND))
            begin
               emit_status = 1'b1;
               status_code = shfd_pkg::STATUS_BAD_SYNC;
            end else if (buffer_last) begin
               emit_status = 1'b1;
               status_code = shfd_pkg::STATUS_TRUNCATED;
            end
         end else if (pos_cur < shfd_pkg::HDR_BYTES) begin
            crc_in = crc_upd;
            case (pos_cur)
               9'd2:    dest_in = rx_byte;
               9'd3:    src_in  = rx_byte;
               9'd4:    cmd_in  = rx_byte;
               default: len_in  = rx_byte;
            endcase
            if (buffer_last) begin
               emit_status = 1'b1;
               status_code = shfd_pkg::STATUS_TRUNCATED;
            end
         end else if (pos_cur < pay_end) begin
            crc_in = crc_upd;
            if (buffer_last) begin
               emit_status = 1'b1;
               status_code = shfd_pkg::STATUS_TRUNCATED;
            end else begin
               emit_payload = 1'b1;
            end
         end else if (pos_cur == pay_end) begin
            low_in = rx_byte;
            if (buffer_last) begin
               emit_status = 1'b1;
               status_code = shfd_pkg::STATUS_TRUNCATED;
            end
         end else begin
            emit_status = 1'b1;
            status_code = ({rx_byte, low_cur} == crc_cur) ? shfd_pkg::STATUS_OK
                                                          : shfd_pkg::STATUS_CRC_BAD;
         end
         if (emit_status) begin
            verdict_in = 1'b1;
         end
      end

      result_valid = step_en && (emit_status || emit_payload);
      result = '0;
      if (emit_status) begin
         result.item_kind      = shfd_pkg::KIND_STATUS;
         result.frame_status   = status_code;
         result.dest_addr      = dest_in;
         result.source_addr    = src_in;
         result.command_code   = cmd_in;
         result.payload_length = len_in;
      end else begin
         result.item_kind     = shfd_pkg::KIND_PAYLOAD;
         result.payload_byte  = emit_payload ? rx_byte : 8'h00;
         result.payload_index = emit_payload ? 8'(pos_cur - shfd_pkg::HDR_BYTES) : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= shfd_pkg::CRC_INIT;
         dest_ff    <= '0;
         src_ff     <= '0;
         cmd_ff     <= '0;
         len_ff     <= '0;
         low_ff     <= '0;
         verdict_ff <= 1'b1;
      end else if (step_en) begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         dest_ff    <= dest_in;
         src_ff     <= src_in;
         cmd_ff     <= cmd_in;
         len_ff     <= len_in;
         low_ff     <= low_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

>>> hdl/sync_header_frame_decoder_crc16.sv
// Top level of the sync-header frame decoder with CRC-16/MODBUS check.
// Depends on shfd_pkg and shfd_core.
//
// Usage:
//   req_ carries the received buffer one byte per item: tdata[7:0] the byte,
//   tuser marks the first byte of a buffer (restarts decoding), tlast the last.
//   rsp_ carries results: tuser 0 is a payload byte with its index, tuser 1 a
//   frame status (ok, bad sync, truncated, crc mismatch) with header fields.
//   An item gives zero or one result; sync, header and first CRC bytes give one
//   only on error or truncation, the last CRC byte the status, bytes after it none.
// Path: an accepted item enters the input register, then passes through decode
//   and the CRC update into the result register.
// Throughput: one item per cycle while rsp_ is not stalled; the unrolled
//   eight-step CRC update sits between the input and result registers.
// Reset: synchronous; both registers empty, decoder idle until a first byte.
// Stall: while rsp_tready is low the result holds; one more item is taken
//   into the input register, then req_tready drops until the result leaves.
module sync_header_frame_decoder_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // buffer_first
   input  logic        req_tlast,   // buffer_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // payload_byte, payload_index, frame_status,
                                    // dest_addr, source_addr, command_code,
                                    // payload_length, zero fill
   output logic        rsp_tuser    // item_kind
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_first_ff;
   logic                 in_last_ff;
   logic                 rsp_valid_ff;
   shfd_pkg::result_type rsp_ff;
   logic                 out_free;
   logic                 advance;
   logic                 core_valid;
   shfd_pkg::result_type core_result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   shfd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .rx_byte      (in_byte_ff),
      .buffer_first (in_first_ff),
      .buffer_last  (in_last_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= core_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      if (out_free && core_valid) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.item_kind;
   assign rsp_tdata  = {6'b000000,
                        rsp_ff.payload_length,
                        rsp_ff.command_code,
                        rsp_ff.source_addr,
                        rsp_ff.dest_addr,
                        2'(rsp_ff.frame_status),
                        rsp_ff.payload_index,
                        rsp_ff.payload_byte};

endmodule

>>> hdl/shfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
// Depends on shfd_pkg and sync_header_frame_decoder_crc16_defines.svh.
`include "sync_header_frame_decoder_crc16_defines.svh"

module shfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   `SHFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `SHFD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   `SHFD_ASSERT_NOW(a_payload_clean, clock, reset, rsp_tvalid && rsp_tuser == shfd_pkg::KIND_PAYLOAD, rsp_tdata[55:16] == 40'd0, "payload item carries status fields")

   `SHFD_ASSERT_NOW(a_status_clean, clock, reset, rsp_tvalid && rsp_tuser == shfd_pkg::KIND_STATUS, rsp_tdata[15:0] == 16'd0 && rsp_tdata[55:50] == 6'd0, "status item carries payload fields")

   `SHFD_ASSERT_NOW(a_stall_backpressure, clock, reset, rsp_tvalid && !rsp_tready && $past(req_tvalid && req_tready) && $past(rsp_tvalid && !rsp_tready), !req_tready, "input taken past a full pipeline")

endmodule

bind sync_header_frame_decoder_crc16 shfd_checker u_shfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
